[src/brc_pkg.sv]
// Shared types and constants for the bandwidth reservation calendar.
// Used by brc_front, brc_queue, brc_back and the top level; no dependencies.
package brc_pkg;

    localparam int DATA_W      = 32;
    localparam int DEF_WINDOW  = 4096;
    // Largest supported window is 65536 units: slot and count fields are sized for it
    localparam int SLOT_MAX_W  = 16;
    localparam int CNT_MAX_W   = 17;
    // Command queue depth, a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [DATA_W-1:0] CAP_RESET = '1;

    // Input command codes
    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_RESERVE = 1'b1;

    // Result codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_OVER_CAP = 2'd1;
    localparam status_t ST_BEYOND   = 2'd2;

    // Work handed from front to back
    typedef enum logic [1:0] {
        OP_NOP,
        OP_CLEAR,
        OP_RESERVE
    } op_t;

    typedef struct packed {
        op_t                   op;
        status_t               status;
        logic [SLOT_MAX_W-1:0] slot;
        logic [CNT_MAX_W-1:0]  count;
        logic [DATA_W-1:0]     bw;
    } q_entry_t;

    // Back end status seen by the front end
    typedef struct packed {
        logic init_busy;
    } back_stat_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_CHECK,
        BK_ADD,
        BK_CLEAR,
        BK_RESULT
    } back_state_t;

endpackage

[src/brc_front.sv]
// Front end: accepts input items, tracks current time and the ring base,
// classifies each item into a queue entry. Depends on brc_pkg.
module brc_front #(
    parameter int WINDOW = brc_pkg::DEF_WINDOW
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic [brc_pkg::DATA_W-1:0]   new_time,
    input  logic [brc_pkg::DATA_W-1:0]   start_offset,
    input  logic [brc_pkg::DATA_W-1:0]   duration,
    input  logic [brc_pkg::DATA_W-1:0]   bandwidth,
    input  brc_pkg::back_stat_t          bk_stat,
    input  logic                         q_full,
    output logic                         q_push,
    output brc_pkg::q_entry_t            q_entry
);
    import brc_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam logic [DATA_W:0]   WIN_WIDE = (DATA_W+1)'(WINDOW);
    localparam logic [DATA_W-1:0] WIN_D    = DATA_W'(WINDOW);
    localparam logic [SLOT_W:0]   WIN_S    = (SLOT_W+1)'(WINDOW);

    logic [DATA_W-1:0] cur_time_reg, cur_time_next;
    logic [SLOT_W-1:0] base_reg, base_next;

    logic [DATA_W-1:0] gap;
    logic              gap_full;
    logic [DATA_W:0]   span_end;
    logic [SLOT_W:0]   adv_sum;
    logic [SLOT_W:0]   res_sum;
    logic [SLOT_W-1:0] adv_base;
    logic [SLOT_W-1:0] res_slot;

    // Hold items while the ring is being cleared or the queue is full
    assign in_ready = !q_full && !bk_stat.init_busy;
    assign q_push   = in_valid && in_ready;

    // Advance: distance moved and the rotated ring base
    assign gap      = new_time - cur_time_reg;
    assign gap_full = (gap >= WIN_D);
    assign adv_sum  = {1'b0, base_reg} + {1'b0, gap[SLOT_W-1:0]};
    assign adv_base = (adv_sum >= WIN_S) ? SLOT_W'(adv_sum - WIN_S) : adv_sum[SLOT_W-1:0];

    // Reserve: end of span relative to now and the first slot
    assign span_end = {1'b0, start_offset} + {1'b0, duration};
    assign res_sum  = {1'b0, base_reg} + {1'b0, start_offset[SLOT_W-1:0]};
    assign res_slot = (res_sum >= WIN_S) ? SLOT_W'(res_sum - WIN_S) : res_sum[SLOT_W-1:0];

    // Classify the item
    always_comb
    begin
        cur_time_next   = cur_time_reg;
        base_next       = base_reg;
        q_entry.op      = OP_NOP;
        q_entry.status  = ST_OK;
        q_entry.slot    = '0;
        q_entry.count   = '0;
        q_entry.bw      = bandwidth;
        if (command == CMD_ADVANCE)
        begin
            if (new_time > cur_time_reg)
            begin
                q_entry.op    = OP_CLEAR;
                q_entry.slot  = SLOT_MAX_W'(base_reg);
                q_entry.count = gap_full ? CNT_MAX_W'(WINDOW) : CNT_MAX_W'(gap[CNT_W-1:0]);
                cur_time_next = new_time;
                // A jump of a full window empties the ring, so any base will do
                base_next     = gap_full ? base_reg : adv_base;
            end
        end
        else
        begin
            if (duration == '0)
            begin
                q_entry.status = ST_OK;
            end
            else if (span_end > WIN_WIDE)
            begin
                q_entry.status = ST_BEYOND;
            end
            else
            begin
                q_entry.op    = OP_RESERVE;
                q_entry.slot  = SLOT_MAX_W'(res_slot);
                q_entry.count = CNT_MAX_W'(duration[CNT_W-1:0]);
            end
        end
    end

    // Time and ring base registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_time_reg <= '0;
            base_reg     <= '0;
        end
        else if (q_push)
        begin
            cur_time_reg <= cur_time_next;
            base_reg     <= base_next;
        end
    end

endmodule

[src/brc_queue.sv]
// Short command queue between front and back end.
// Depends on brc_pkg for the entry type and depth.
module brc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  brc_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output brc_pkg::q_entry_t head
);
    import brc_pkg::*;

    q_entry_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg, fill_next;

    assign full    = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        fill_next = fill_reg;
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[src/brc_back.sv]
// Back end: owns the reserved-amount ring memory, runs clear, check and
// add passes, and holds the result register. Depends on brc_pkg.
module brc_back #(
    parameter int WINDOW = brc_pkg::DEF_WINDOW
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [brc_pkg::DATA_W-1:0] cap,
    input  logic                       q_valid,
    input  brc_pkg::q_entry_t          head,
    output logic                       q_pop,
    output brc_pkg::back_stat_t        bk_stat,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status
);
    import brc_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

    back_state_t state_reg, state_next;

    logic [DATA_W-1:0] mem [WINDOW];
    logic [DATA_W-1:0] rdata_reg;

    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [SLOT_W-1:0] wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [CNT_W-1:0]  span_reg, span_next;
    logic [DATA_W-1:0] bw_reg, bw_next;
    logic              rv_reg, rv_next;
    status_t           res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;

    logic              rd_en;
    logic              wr_en;
    logic [DATA_W-1:0] wr_data;
    logic              over;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        r = (s == SLOT_LAST) ? '0 : s + 1'b1;
        return r;
    endfunction

    assign bk_stat.init_busy = (state_reg == BK_INIT);
    assign out_valid         = out_valid_reg;
    assign status            = out_status_reg;
    assign over = ({1'b0, rdata_reg} + {1'b0, bw_reg}) > {1'b0, cap};

    // Sequence the passes over the ring
    always_comb
    begin
        state_next      = state_reg;
        rd_slot_next    = rd_slot_reg;
        wr_slot_next    = wr_slot_reg;
        start_next      = start_reg;
        left_next       = left_reg;
        span_next       = span_reg;
        bw_next         = bw_reg;
        rv_next         = 1'b0;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_data         = '0;
        q_pop           = 1'b0;
        unique case (state_reg)
            BK_INIT:
            begin
                wr_en        = 1'b1;
                wr_slot_next = slot_inc(wr_slot_reg);
                if (wr_slot_reg == SLOT_LAST)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (head.op)
                        OP_CLEAR:
                        begin
                            wr_slot_next = head.slot[SLOT_W-1:0];
                            left_next    = head.count[CNT_W-1:0];
                            state_next   = BK_CLEAR;
                        end
                        OP_RESERVE:
                        begin
                            rd_slot_next = head.slot[SLOT_W-1:0];
                            start_next   = head.slot[SLOT_W-1:0];
                            left_next    = head.count[CNT_W-1:0];
                            span_next    = head.count[CNT_W-1:0];
                            bw_next      = head.bw;
                            state_next   = BK_CHECK;
                        end
                        default:
                        begin
                            res_next   = head.status;
                            state_next = BK_RESULT;
                        end
                    endcase
                end
            end
            BK_CHECK:
            begin
                // Issue reads, one unit a cycle
                if (left_reg != '0)
                begin
                    rd_en        = 1'b1;
                    rd_slot_next = slot_inc(rd_slot_reg);
                    left_next    = left_reg - 1'b1;
                    rv_next      = 1'b1;
                end
                // Test returned amounts; drop the item on the first unit over cap
                if (rv_reg)
                begin
                    if (over)
                    begin
                        res_next   = ST_OVER_CAP;
                        rv_next    = 1'b0;
                        state_next = BK_RESULT;
                    end
                    else if (left_reg == '0)
                    begin
                        rd_slot_next = start_reg;
                        wr_slot_next = start_reg;
                        left_next    = span_reg;
                        rv_next      = 1'b0;
                        state_next   = BK_ADD;
                    end
                end
            end
            BK_ADD:
            begin
                if (left_reg != '0)
                begin
                    rd_en        = 1'b1;
                    rd_slot_next = slot_inc(rd_slot_reg);
                    left_next    = left_reg - 1'b1;
                    rv_next      = 1'b1;
                end
                // Write back each amount in the cycle after its read
                if (rv_reg)
                begin
                    wr_en        = 1'b1;
                    wr_data      = rdata_reg + bw_reg;
                    wr_slot_next = slot_inc(wr_slot_reg);
                    if (left_reg == '0)
                    begin
                        res_next   = ST_OK;
                        state_next = BK_RESULT;
                    end
                end
            end
            BK_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_slot_next = slot_inc(wr_slot_reg);
                left_next    = left_reg - 1'b1;
                if (left_reg == CNT_W'(1))
                begin
                    res_next   = ST_OK;
                    state_next = BK_RESULT;
                end
            end
            BK_RESULT:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg;
                    state_next      = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_INIT;
            wr_slot_reg   <= '0;
            rd_slot_reg   <= '0;
            left_reg      <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_slot_reg   <= wr_slot_next;
            rd_slot_reg   <= rd_slot_next;
            left_reg      <= left_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        span_reg       <= span_next;
        bw_reg         <= bw_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_slot_reg];
        end
    end

endmodule

[src/bandwidth_reservation_calendar.sv]
// Top level of the bandwidth reservation calendar: capacity register and
// front / queue / back wiring. Depends on brc_pkg, brc_front, brc_queue, brc_back.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, command, new_time,       | input
//          | start_offset, duration, bandwidth            |
//  out     | out_valid, out_ready, status                 | output
//  cfg     | cfg_valid, cfg_ready, cfg_data (resource_cap)| input
//
// A reserve over D units makes a check pass and, unless a unit goes over cap,
// an add pass through the one-read, one-write ring memory; an advance by G
// units clears min(G, WINDOW) slots. After reset the back end clears the ring,
// during which in_ready stays low; configuration transfers are taken every cycle.
// A stalled result holds in the output register while the front end keeps
// taking items into the two-entry queue.
module bandwidth_reservation_calendar #(
    parameter int WINDOW = brc_pkg::DEF_WINDOW
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       command,
    input  logic [brc_pkg::DATA_W-1:0] new_time,
    input  logic [brc_pkg::DATA_W-1:0] start_offset,
    input  logic [brc_pkg::DATA_W-1:0] duration,
    input  logic [brc_pkg::DATA_W-1:0] bandwidth,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [brc_pkg::DATA_W-1:0] cfg_data
);
    import brc_pkg::*;

    logic [DATA_W-1:0] cap_reg;
    back_stat_t        bk_stat;
    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    q_entry_t          q_in;
    q_entry_t          q_head;

    // Capacity register, written at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    brc_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .new_time     (new_time),
        .start_offset (start_offset),
        .duration     (duration),
        .bandwidth    (bandwidth),
        .bk_stat      (bk_stat),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_in)
    );

    brc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .head       (q_head)
    );

    brc_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_reg),
        .q_valid   (q_valid),
        .head      (q_head),
        .q_pop     (q_pop),
        .bk_stat   (bk_stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status)
    );

endmodule
